@@ design/dda_pkg.sv @@
`default_nettype none

package dda_pkg;

  localparam int unsigned COORD_BITS_DEF = 12;
  localparam int unsigned FRAC_BITS_DEF  = 16;

  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIVX,
    S_DIVY,
    S_ROUND
  } state_e;

  // launch request for the increment divider
  typedef struct packed {
    logic start;
    logic neg;
  } div_ctl_t;

endpackage

`default_nettype wire

@@ design/dda_if.sv @@
`default_nettype none

interface dda_in_if
  import dda_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic                         opcode;
  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;

  modport source (output valid, opcode, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, opcode, start_x, start_y, end_x, end_y, output ready);
endinterface

interface dda_out_if
  import dda_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] pixel_x;
  logic signed [COORD_BITS-1:0] pixel_y;
  logic                         last_pixel;
  logic                         idle_step;

  modport source (output valid, pixel_x, pixel_y, last_pixel, idle_step, input ready);
  modport sink   (input valid, pixel_x, pixel_y, last_pixel, idle_step, output ready);
endinterface

`default_nettype wire

@@ design/dda_div.sv @@
`default_nettype none

// Restoring divider, one quotient bit per cycle: inc = round(mag * 2^F / div),
// ties away from zero, then signed. Requires mag <= div, div != 0.
module dda_div
  import dda_pkg::*;
#(
  parameter int unsigned SW        = COORD_BITS_DEF + 1,
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire div_ctl_t               ctl_i,
  input  wire logic [SW-1:0]          mag_i,
  input  wire logic [SW-1:0]          div_i,
  output logic                        done_o,
  output logic signed [FRAC_BITS+1:0] inc_o
);

  localparam int unsigned CW   = $clog2(FRAC_BITS + 2);
  localparam logic [CW-1:0] LAST = CW'(FRAC_BITS + 1);

  logic              busy_q;
  logic [CW-1:0]     cnt_q;
  logic              done_q;
  logic [SW:0]       r_q;
  logic [SW-1:0]     s_q;
  logic [FRAC_BITS:0] q_q;
  logic              neg_q;
  logic signed [FRAC_BITS+1:0] inc_q;

  logic [SW:0]   r_in;
  logic [SW+1:0] diff;
  logic          ge;
  logic [FRAC_BITS+1:0] q_rnd;

  // first pass compares mag itself (integer bit), later passes shift
  assign r_in  = (cnt_q == '0) ? r_q : {r_q[SW-1:0], 1'b0};
  assign diff  = {1'b0, r_in} - {2'b00, s_q};
  assign ge    = ~diff[SW+1];
  assign q_rnd = {1'b0, q_q} + (FRAC_BITS + 2)'(ge);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (ctl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      r_q   <= {1'b0, mag_i};
      s_q   <= div_i;
      neg_q <= ctl_i.neg;
      q_q   <= '0;
    end else if (busy_q) begin
      if (cnt_q == LAST) begin
        // rounding pass: 2r >= div bumps the quotient
        inc_q <= neg_q ? -q_rnd : q_rnd;
      end else begin
        r_q <= ge ? diff[SW:0] : r_in;
        q_q <= {q_q[FRAC_BITS-1:0], ge};
      end
    end
  end

  assign done_o = done_q;
  assign inc_o  = inc_q;

endmodule

`default_nettype wire

@@ design/dda_line_rasterizer.sv @@
`default_nettype none

// DDA line rasterizer. A start item (opcode 0) carries both endpoints; its
// result, the start pixel, is loaded in the cycle the item is taken. The block
// then derives the per-step increments dx/steps and dy/steps with one shared
// restoring divider that yields one quotient bit per cycle, first for x and
// then for y, and keeps the input closed until both are done. A zero-length
// line returns its start pixel flagged last and starts no divide. Each step
// item (opcode 1) first adds the increments to the position, then rounds
// half away from zero and loads the output register once it is free. A step
// with no line active returns an idle flag with zero coordinates directly. The
// last pixel of a line is flagged; a new start abandons any line in progress.
// The input is taken only in the idle state and while the output register is
// free or being drained.
module dda_line_rasterizer
  import dda_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  dda_in_if.sink     in_i,
  dda_out_if.source  out_o
);

  localparam int unsigned SW = COORD_BITS + 1;         // step count / delta width
  localparam int unsigned PW = COORD_BITS + FRAC_BITS; // position width
  localparam int unsigned IW = FRAC_BITS + 2;          // increment width

  state_e state_q, state_d;

  // line state
  logic signed [PW-1:0] pos_x_q, pos_y_q;
  logic signed [IW-1:0] step_x_q, step_y_q;
  logic [SW-1:0]        steps_left_q;
  logic                 line_active_q;
  logic [SW-1:0]        mag_y_q;
  logic                 neg_y_q;

  // output register
  logic                         out_valid_q;
  logic signed [COORD_BITS-1:0] out_x_q, out_y_q;
  logic                         out_last_q, out_idle_q;

  // start decode
  logic signed [SW-1:0] dx, dy;
  logic [SW-1:0]        ax, ay, steps;

  logic in_ready, acc, out_free, is_start, is_step;

  div_ctl_t             div_ctl;
  logic [SW-1:0]        div_mag, div_den;
  logic                 div_done;
  logic signed [IW-1:0] div_inc;

  logic signed [COORD_BITS-1:0] rnd_x, rnd_y;

  assign dx    = SW'(in_i.end_x) - SW'(in_i.start_x);
  assign dy    = SW'(in_i.end_y) - SW'(in_i.start_y);
  assign ax    = dx[SW-1] ? -dx : dx;
  assign ay    = dy[SW-1] ? -dy : dy;
  assign steps = (ax > ay) ? ax : ay;

  assign out_free = ~out_valid_q | out_o.ready;
  assign in_ready = (state_q == S_IDLE) && out_free;
  assign acc      = in_i.valid & in_ready;
  assign is_start = acc && (in_i.opcode == OP_START);
  assign is_step  = acc && (in_i.opcode == OP_STEP);

  // round half away from zero, wrap to the coordinate width
  function automatic logic signed [COORD_BITS-1:0] round_pix(logic signed [PW-1:0] v);
    logic [PW-1:0]         mag;
    logic [PW-1:0]         sum;
    logic [COORD_BITS-1:0] r;
    mag = v[PW-1] ? -v : v;
    sum = mag + (PW'(1) << (FRAC_BITS - 1));
    r   = sum[PW-1:FRAC_BITS];
    return v[PW-1] ? -r : r;
  endfunction

  assign rnd_x = round_pix(pos_x_q);
  assign rnd_y = round_pix(pos_y_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // sequencer: divider launches and next state
  always_comb begin
    state_d       = state_q;
    div_ctl.start = 1'b0;
    div_ctl.neg   = dx[SW-1];
    div_mag       = ax;
    div_den       = steps;
    case (state_q)
      S_IDLE: begin
        if (is_start && steps != '0) begin
          div_ctl.start = 1'b1;
          state_d       = S_DIVX;
        end else if (is_step && line_active_q) begin
          state_d = S_ROUND;
        end
      end
      S_DIVX: begin
        div_mag     = mag_y_q;
        div_den     = steps_left_q;
        div_ctl.neg = neg_y_q;
        if (div_done) begin
          div_ctl.start = 1'b1;
          state_d       = S_DIVY;
        end
      end
      S_DIVY: begin
        if (div_done) begin
          state_d = S_IDLE;
        end
      end
      S_ROUND: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  dda_div #(
    .SW        (SW),
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (div_ctl),
    .mag_i  (div_mag),
    .div_i  (div_den),
    .done_o (div_done),
    .inc_o  (div_inc)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_active_q <= 1'b0;
      steps_left_q  <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      // an active step loads its result from S_ROUND, once the output register is free
      if ((acc && !(is_step && line_active_q)) || (state_q == S_ROUND && out_free)) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (is_start) begin
        line_active_q <= 1'b0;   // any old line is dropped
        steps_left_q  <= steps;
      end else if (is_step && line_active_q) begin
        steps_left_q <= steps_left_q - 1'b1;
      end
      if (state_q == S_DIVY && div_done) begin
        line_active_q <= 1'b1;
      end
      if (state_q == S_ROUND && out_free) begin
        if (steps_left_q == '0) begin
          line_active_q <= 1'b0;
        end
      end
    end
  end

  // datapath and output payload
  always_ff @(posedge clk_i) begin
    if (is_start) begin
      pos_x_q    <= {in_i.start_x, {FRAC_BITS{1'b0}}};
      pos_y_q    <= {in_i.start_y, {FRAC_BITS{1'b0}}};
      mag_y_q    <= ay;
      neg_y_q    <= dy[SW-1];
      out_x_q    <= in_i.start_x;
      out_y_q    <= in_i.start_y;
      out_last_q <= (steps == '0);
      out_idle_q <= 1'b0;
    end else if (is_step) begin
      if (line_active_q) begin
        pos_x_q <= pos_x_q + PW'(step_x_q);
        pos_y_q <= pos_y_q + PW'(step_y_q);
      end else begin
        out_x_q    <= '0;
        out_y_q    <= '0;
        out_last_q <= 1'b0;
        out_idle_q <= 1'b1;
      end
    end
    if (state_q == S_DIVX && div_done) begin
      step_x_q <= div_inc;
    end
    if (state_q == S_DIVY && div_done) begin
      step_y_q <= div_inc;
    end
    if (state_q == S_ROUND && out_free) begin
      out_x_q    <= rnd_x;
      out_y_q    <= rnd_y;
      out_last_q <= (steps_left_q == '0);
      out_idle_q <= 1'b0;
    end
  end

  assign in_i.ready       = in_ready;
  assign out_o.valid      = out_valid_q;
  assign out_o.pixel_x    = out_x_q;
  assign out_o.pixel_y    = out_y_q;
  assign out_o.last_pixel = out_last_q;
  assign out_o.idle_step  = out_idle_q;

  // divider finishes only while the sequencer waits on it
  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIVX || state_q == S_DIVY))
    else $error("divider done outside a divide state");

  // a resting active line always has pixels left
  a_active_has_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (line_active_q && state_q == S_IDLE) |-> (steps_left_q != '0))
    else $error("active line with no steps left");

  // step with no line gives an idle-flagged result right away
  a_idle_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (is_step && !line_active_q) |=> (out_valid_q && out_idle_q && !out_last_q))
    else $error("idle step result missing");

  // zero-length start returns one last pixel and stays idle
  a_zero_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (is_start && steps == '0) |=> (out_valid_q && out_last_q && state_q == S_IDLE))
    else $error("zero-length line handled wrong");

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

// Line rasterizer testbench: directed lines and an output hold-off first, then
// random line sequences and long lines. Every accepted item is run through a local
// fixed-point DDA predictor. The predicted pixel is queued and compared against
// each pixel that leaves the block.
module testbench;
  import dda_pkg::*;

  localparam int unsigned COORD_W = COORD_BITS_DEF;
  localparam int unsigned FRAC_W  = FRAC_BITS_DEF;
  localparam int unsigned POS_W   = COORD_W + FRAC_W;  // position: int.frac
  localparam int unsigned INC_W   = FRAC_W + 2;        // increment: 2 int bits
  localparam int          CMIN    = -(1 << (COORD_W - 1));
  localparam int          CMAX    = (1 << (COORD_W - 1)) - 1;
  // A start item keeps the divider busy after its pixel is out, so the final
  // quiet period covers both divides with margin.
  localparam int unsigned DRAIN_CYCLES  = 2 * FRAC_W + 60;
  localparam int unsigned RANDOM_ITEMS  = 1000;

  typedef struct packed {
    logic                      op;
    logic signed [COORD_W-1:0] sx;
    logic signed [COORD_W-1:0] sy;
    logic signed [COORD_W-1:0] ex;
    logic signed [COORD_W-1:0] ey;
  } line_cmd_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic                      last;
    logic                      idle;
  } pixel_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  dda_in_if  #(.COORD_BITS(COORD_W)) in_bus  ();
  dda_out_if #(.COORD_BITS(COORD_W)) out_bus ();

  dda_line_rasterizer #(
    .COORD_BITS(COORD_W),
    .FRAC_BITS (FRAC_W)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor state, mirrors the block's registers
  // --------------------------------------------------------------------------
  logic signed [POS_W-1:0] cur_x, cur_y;
  logic signed [INC_W-1:0] inc_x, inc_y;
  logic        [12:0]      pix_left;
  logic                    drawing;

  pixel_t pending_pixels[$];
  int unsigned error_count = 0;
  int unsigned items_sent  = 0;

  // knobs shared with the output-side process
  bit          burst_mode       = 1'b0;  // no gaps on either side
  int unsigned long_hold_cycles = 0;     // one-shot request for a long stall

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  // d * 2^FRAC / steps, rounded to nearest, ties away from zero
  function automatic logic signed [INC_W-1:0] fixed_slope(input longint d,
                                                          input longint steps);
    longint mag, q;
    mag = (d < 0) ? -d : d;
    q   = ((mag << (FRAC_W + 1)) + steps) / (2 * steps);
    if (d < 0) q = -q;
    return q[INC_W-1:0];
  endfunction

  // position to pixel, half away from zero, wrapped to coordinate width
  function automatic logic signed [COORD_W-1:0] round_coord(
      input logic signed [POS_W-1:0] v);
    longint mag, r;
    mag = (v < 0) ? -longint'(v) : longint'(v);
    r   = (mag + (longint'(1) << (FRAC_W - 1))) >> FRAC_W;
    if (v < 0) r = -r;
    return r[COORD_W-1:0];
  endfunction

  // advance the predictor by one accepted item and return its pixel
  task automatic rasterize_cmd(input line_cmd_t c, output pixel_t px);
    longint dx, dy, ax, ay, steps;
    px = '0;
    if (c.op == OP_START) begin
      dx    = longint'($signed(c.ex)) - longint'($signed(c.sx));
      dy    = longint'($signed(c.ey)) - longint'($signed(c.sy));
      ax    = (dx < 0) ? -dx : dx;
      ay    = (dy < 0) ? -dy : dy;
      steps = (ax > ay) ? ax : ay;
      px.x  = c.sx;
      px.y  = c.sy;
      cur_x = {c.sx, {FRAC_W{1'b0}}};
      cur_y = {c.sy, {FRAC_W{1'b0}}};
      if (steps == 0) begin
        // zero-length line: start pixel only, flagged last, nothing active
        inc_x    = '0;
        inc_y    = '0;
        pix_left = '0;
        drawing  = 1'b0;
        px.last  = 1'b1;
      end else begin
        inc_x    = fixed_slope(dx, steps);
        inc_y    = fixed_slope(dy, steps);
        pix_left = steps[12:0];
        drawing  = 1'b1;
      end
    end else if (!drawing) begin
      px.idle = 1'b1;  // step with no line: zero pixel, state untouched
    end else begin
      cur_x    = cur_x + inc_x;
      cur_y    = cur_y + inc_y;
      pix_left = pix_left - 13'd1;
      px.x     = round_coord(cur_x);
      px.y     = round_coord(cur_y);
      if (pix_left == '0) begin
        px.last = 1'b1;
        drawing = 1'b0;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------
  // mostly back-to-back or short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (burst_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offer one item and wait for it to be taken. valid is left high on
  // return so a back-to-back item keeps it asserted without a glitch.
  task automatic send_item(input line_cmd_t c);
    int unsigned gap;
    pixel_t      px;
    gap = pick_gap();
    if (gap != 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_bus.valid   <= 1'b1;
    in_bus.opcode  <= c.op;
    in_bus.start_x <= c.sx;
    in_bus.start_y <= c.sy;
    in_bus.end_x   <= c.ex;
    in_bus.end_y   <= c.ey;
    do @(posedge clk_i); while (in_bus.ready !== 1'b1);
    rasterize_cmd(c, px);
    pending_pixels.push_back(px);
    items_sent++;
  endtask

  task automatic send_start(input int x0, input int y0, input int x1, input int y1);
    line_cmd_t c;
    c.op = OP_START;
    c.sx = x0[COORD_W-1:0];
    c.sy = y0[COORD_W-1:0];
    c.ex = x1[COORD_W-1:0];
    c.ey = y1[COORD_W-1:0];
    send_item(c);
  endtask

  // step items carry junk in the coordinate fields, which must be ignored
  task automatic send_steps(input int unsigned n);
    line_cmd_t   c;
    logic [63:0] junk;
    repeat (n) begin
      junk = {$urandom, $urandom};
      c    = junk[$bits(line_cmd_t)-1:0];
      c.op = OP_STEP;
      send_item(c);
    end
  endtask

  // endpoint within +-maxd of the start, folded back into range
  function automatic int near_coord(input int s, input int maxd);
    int d, e;
    d = int'($urandom_range(0, 2 * maxd)) - maxd;
    e = s + d;
    if (e < CMIN || e > CMAX) e = s - d;
    return e;
  endfunction

  function automatic int rand_coord();
    return int'($urandom_range(0, CMAX - CMIN)) + CMIN;
  endfunction

  function automatic int line_len(input int x0, input int y0, input int x1, input int y1);
    int ax, ay;
    ax = (x1 > x0) ? x1 - x0 : x0 - x1;
    ay = (y1 > y0) ? y1 - y0 : y0 - y1;
    return (ax > ay) ? ax : ay;
  endfunction

  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Output side: random ready, with an optional long hold-off
  // --------------------------------------------------------------------------
  initial begin : sink_ctrl
    int unsigned hold;
    int unsigned r;
    hold          = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_hold_cycles != 0) begin
        hold             = long_hold_cycles;
        long_hold_cycles = 0;
      end
      if (hold != 0) begin
        hold--;
        out_bus.ready <= 1'b0;
      end else if (burst_mode) begin
        out_bus.ready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          out_bus.ready <= 1'b1;
        end else if (r < 96) begin
          out_bus.ready <= 1'b0;
          hold = $urandom_range(0, 3);
        end else begin
          out_bus.ready <= 1'b0;
          hold = $urandom_range(10, 50);
        end
      end
    end
  end

  // every pixel taken is matched against the oldest prediction
  always @(posedge clk_i) begin : pixel_check
    pixel_t want;
    if (rst_ni && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch($sformatf("unexpected pixel (%0d,%0d)",
                                  out_bus.pixel_x, out_bus.pixel_y));
      end else begin
        want = pending_pixels.pop_front();
        if (out_bus.pixel_x !== want.x)
          report_mismatch($sformatf("pixel_x got %0d want %0d", out_bus.pixel_x, want.x));
        if (out_bus.pixel_y !== want.y)
          report_mismatch($sformatf("pixel_y got %0d want %0d", out_bus.pixel_y, want.y));
        if (out_bus.last_pixel !== want.last)
          report_mismatch($sformatf("last_pixel got %b want %b", out_bus.last_pixel,
                                    want.last));
        if (out_bus.idle_step !== want.idle)
          report_mismatch($sformatf("idle_step got %b want %b", out_bus.idle_step,
                                    want.idle));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // steps straight out of reset: idle flags only
  task automatic test_idle_after_reset();
    send_steps(2);
  endtask

  // zero-length lines at both coordinate extremes, then a step: still idle
  task automatic test_zero_length();
    send_start(CMIN, CMIN, CMIN, CMIN);
    send_start(CMAX, CMAX, CMAX, CMAX);
    send_steps(1);
  endtask

  // half-pixel positions on both signs, to pin down away-from-zero rounding
  task automatic test_round_ties();
    send_start(0, 0, 4, 2);
    send_steps(4);
    send_start(-1, -1, -5, -3);
    send_steps(4);
  endtask

  // full-range diagonal, abandoned by a new start; then a vertical line with
  // one step past its end
  task automatic test_extremes_abandon();
    send_start(CMIN, CMAX, CMAX, CMIN);
    send_steps(3);
    send_start(CMAX, CMIN, CMIN, CMAX);
    send_steps(2);
    send_start(5, 5, 5, 9);
    send_steps(5);
  endtask

  // Output held off while the input keeps offering items back-to-back: the
  // output register fills and the block has to stall its input.
  task automatic test_output_hold();
    burst_mode       = 1'b1;
    long_hold_cycles = 300;
    send_start(-7, 3, 9, -2);
    send_steps(20);
    burst_mode = 1'b0;
    wait_drained();
  endtask

  // mostly well-formed lines with random content, plus noise and broken runs
  task automatic test_random_lines();
    int unsigned kind, len, n;
    int          x0, y0, x1, y1;
    while (items_sent < RANDOM_ITEMS) begin
      burst_mode = ($urandom_range(0, 9) == 0);
      kind       = $urandom_range(0, 99);
      if (kind < 70) begin
        x0 = rand_coord();
        y0 = rand_coord();
        if ($urandom_range(0, 99) < 85) begin
          x1  = near_coord(x0, 24);
          y1  = near_coord(y0, 24);
          len = line_len(x0, y0, x1, y1);
          n   = $urandom_range(0, 99);
          if (n < 70)      n = len;                          // whole line
          else if (n < 85) n = (len == 0) ? 0 : $urandom_range(0, len - 1);
          else             n = len + $urandom_range(1, 3);   // run past end
        end else begin
          // wide lines, cut short by the next start
          if ($urandom_range(0, 1) == 0) begin
            x1 = near_coord(x0, 300);
            y1 = near_coord(y0, 300);
          end else begin
            x1 = rand_coord();
            y1 = rand_coord();
          end
          n = $urandom_range(0, 20);
        end
        send_start(x0, y0, x1, y1);
        send_steps(n);
      end else if (kind < 85) begin
        send_steps($urandom_range(1, 4));
      end else begin
        x0 = rand_coord();
        y0 = rand_coord();
        if ($urandom_range(0, 1) == 0) send_start(x0, y0, x0, y0);
        else send_start(x0, y0, rand_coord(), rand_coord());
      end
    end
    burst_mode = 1'b0;
  endtask

  // two long lines, x-major and y-major, each stepped one pixel past its end
  task automatic test_long_lines();
    int x0, y0, x1, y1;
    x0 = CMIN + int'($urandom_range(0, 40));
    x1 = x0 + 200 + int'($urandom_range(0, 60));
    y0 = rand_coord();
    y1 = near_coord(y0, 150);
    send_start(x0, y0, x1, y1);
    send_steps(line_len(x0, y0, x1, y1) + 1);
    y0 = CMAX - int'($urandom_range(0, 40));
    y1 = y0 - 200 - int'($urandom_range(0, 60));
    x0 = rand_coord();
    x1 = near_coord(x0, 150);
    send_start(x0, y0, x1, y1);
    send_steps(line_len(x0, y0, x1, y1) + 1);
  endtask

  initial begin : main
    in_bus.valid   <= 1'b0;
    in_bus.opcode  <= OP_START;
    in_bus.start_x <= '0;
    in_bus.start_y <= '0;
    in_bus.end_x   <= '0;
    in_bus.end_y   <= '0;
    cur_x    = '0;
    cur_y    = '0;
    inc_x    = '0;
    inc_y    = '0;
    pix_left = '0;
    drawing  = 1'b0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_idle_after_reset();
    test_zero_length();
    test_round_ties();
    test_extremes_abandon();
    test_output_hold();
    test_random_lines();
    test_long_lines();
    wait_drained();

    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("ERROR: run timed out with %0d pixels outstanding", pending_pixels.size());
    $display("Verification failed");
    $finish;
  end

endmodule

@@ sim.f @@
design/dda_pkg.sv
design/dda_if.sv
design/dda_div.sv
design/dda_line_rasterizer.sv
tb/testbench.sv
